>>> rtl/pdfi_pkg.sv
// Package for the polyphase decimate / kernel / interpolate filter chain.
// Holds data widths, bank and register codes and parameter defaults.
// No dependencies.
package pdfi_pkg;

   localparam int DATA_W          = 16;
   localparam int COEF_W          = 16;
   localparam int ACC_W           = DATA_W + COEF_W;
   localparam int NBANK           = 4;
   localparam int PHASE_TAPS_DEF  = 32;
   localparam int KERNEL_TAPS_DEF = 128;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int BANK_TAPS_W     = 6;
   localparam int KERN_TAPS_W     = 8;

   localparam logic       FUNC_SAMPLE = 1'b0;
   localparam logic       FUNC_COEF   = 1'b1;
   localparam logic [2:0] KERNEL_BANK = 3'd4;

   localparam logic [2:0] REG_TAPS_BANK0  = 3'd0;
   localparam logic [2:0] REG_TAPS_BANK1  = 3'd1;
   localparam logic [2:0] REG_TAPS_BANK2  = 3'd2;
   localparam logic [2:0] REG_TAPS_BANK3  = 3'd3;
   localparam logic [2:0] REG_TAPS_KERNEL = 3'd4;

   typedef enum logic [1:0] {
      JOB_DEC,
      JOB_KER,
      JOB_INT
   } job_type;

endpackage

>>> rtl/pdfi_if.sv
// Valid/ready channel interfaces for request and response transfers.
// Depends on pdfi_pkg for field widths.
interface pdfi_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 func;
   logic signed [pdfi_pkg::DATA_W-1:0]   sample_in;
   logic        [2:0]                    coef_bank;
   logic        [6:0]                    coef_index;
   logic signed [pdfi_pkg::COEF_W-1:0]   coef_value;

   modport source (output valid, func, sample_in, coef_bank, coef_index, coef_value,
                   input ready);
   modport sink   (input valid, func, sample_in, coef_bank, coef_index, coef_value,
                   output ready);
endinterface

interface pdfi_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pdfi_pkg::DATA_W-1:0]   sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink   (input valid, sample_out, output ready);
endinterface

>>> rtl/polyphase_decimate_filter_interpolate.sv
// Polyphase decimate-by-4, low-rate kernel and interpolate-by-4 FIR chain.
// Each pass runs on the shared MAC; a sample runs the dec and int passes, plus the kernel
// pass at phase 0, then the response is registered. Request ready returns in the same cycle
// as the response valid. Coefficient writes are taken in the idle state and go straight
// into coefficient memory. Reset clears control, then a clearing pass zeroes all
// 8*PHASE_TAPS+KERNEL_TAPS delay-line entries; no transfer until it ends.
module polyphase_decimate_filter_interpolate #(
   parameter int PHASE_TAPS  = pdfi_pkg::PHASE_TAPS_DEF,
   parameter int KERNEL_TAPS = pdfi_pkg::KERNEL_TAPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   pdfi_req_if.sink                          req_chan,
   pdfi_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pdfi_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [pdfi_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [pdfi_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import pdfi_pkg::*;

   localparam int LMAX  = (PHASE_TAPS > KERNEL_TAPS) ? PHASE_TAPS : KERNEL_TAPS;
   localparam int OW    = (LMAX > 1) ? $clog2(LMAX) : 1;
   localparam int CNTW  = $clog2(LMAX + 1);
   localparam int TW    = (CNTW > KERN_TAPS_W) ? CNTW : KERN_TAPS_W;
   localparam int DM    = 8 * PHASE_TAPS + KERNEL_TAPS;
   localparam int CM    = 4 * PHASE_TAPS + KERNEL_TAPS;
   localparam int DAW   = $clog2(DM);
   localparam int CAW   = $clog2(CM);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WRITE,
      S_RUN,
      S_DONE
   } state_type;

   state_type                    state_ff;
   job_type                      job_ff;
   logic [1:0]                   phase_ff;
   logic [1:0]                   bank_ff;
   logic signed [DATA_W-1:0]     x_ff;
   logic signed [DATA_W-1:0]     part_ff [NBANK];
   logic signed [DATA_W-1:0]     low_ff;
   logic [OW-1:0]                dptr_ff [NBANK];
   logic [OW-1:0]                iptr_ff [NBANK];
   logic [OW-1:0]                kptr_ff;
   logic [OW-1:0]                off_ff;
   logic [CNTW-1:0]              cnt_ff;
   logic                         rd_v_ff;
   logic                         prod_v_ff;
   logic signed [ACC_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic [DAW-1:0]               clr_ff;
   logic                         rsp_v_ff;
   logic signed [DATA_W-1:0]     out_ff;
   logic [BANK_TAPS_W-1:0]       taps_bank_ff [NBANK];
   logic [KERN_TAPS_W-1:0]       taps_kern_ff;

   logic signed [DATA_W-1:0]     data_mem [DM];
   logic signed [COEF_W-1:0]     coef_mem [CM];
   logic signed [DATA_W-1:0]     rdata_ff;
   logic signed [COEF_W-1:0]     rcoef_ff;

   logic [DAW-1:0]               base_sel;
   logic [CAW-1:0]               cbase_sel;
   logic [OW-1:0]                ptr_sel;
   logic [OW-1:0]                last_off;
   logic [TW-1:0]                taps_sel;
   logic [TW-1:0]                depth_sel;
   logic [CNTW-1:0]              taps_eff;
   logic [OW-1:0]                new_ptr;
   logic                         issue;
   logic                         run_end;
   logic signed [DATA_W-1:0]     res;
   logic signed [DATA_W-1:0]     sum_part;
   logic                         req_xfer;
   logic                         cfg_wr;
   logic [2:0]                   cfg_idx;
   logic                         cw_ok;
   logic [CAW-1:0]               cw_addr;
   logic                         dw_en;
   logic [DAW-1:0]               dw_addr;
   logic signed [DATA_W-1:0]     dw_data;

   assign pready   = 1'b1;
   assign cfg_wr   = psel && penable && pwrite && pready;
   assign cfg_idx  = paddr[4:2];
   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_v_ff;
   assign rsp_chan.sample_out = out_ff;

   always_comb begin
      prdata = '0;
      case (cfg_idx)
         REG_TAPS_BANK0:  prdata = CSR_DATA_W'(taps_bank_ff[0]);
         REG_TAPS_BANK1:  prdata = CSR_DATA_W'(taps_bank_ff[1]);
         REG_TAPS_BANK2:  prdata = CSR_DATA_W'(taps_bank_ff[2]);
         REG_TAPS_BANK3:  prdata = CSR_DATA_W'(taps_bank_ff[3]);
         REG_TAPS_KERNEL: prdata = CSR_DATA_W'(taps_kern_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      base_sel  = '0;
      cbase_sel = '0;
      ptr_sel   = kptr_ff;
      taps_sel  = TW'(taps_kern_ff);
      depth_sel = TW'(KERNEL_TAPS);
      case (job_ff)
         JOB_DEC: begin
            base_sel  = DAW'(int'(bank_ff) * PHASE_TAPS);
            cbase_sel = CAW'(int'(bank_ff) * PHASE_TAPS);
            ptr_sel   = dptr_ff[bank_ff];
            taps_sel  = TW'(taps_bank_ff[bank_ff]);
            depth_sel = TW'(PHASE_TAPS);
         end
         JOB_INT: begin
            base_sel  = DAW'(4 * PHASE_TAPS + int'(bank_ff) * PHASE_TAPS);
            cbase_sel = CAW'(int'(bank_ff) * PHASE_TAPS);
            ptr_sel   = iptr_ff[bank_ff];
            taps_sel  = TW'(taps_bank_ff[bank_ff]);
            depth_sel = TW'(PHASE_TAPS);
         end
         JOB_KER: begin
            base_sel  = DAW'(8 * PHASE_TAPS);
            cbase_sel = CAW'(4 * PHASE_TAPS);
         end
         default: begin
            base_sel  = '0;
         end
      endcase
      last_off = OW'(depth_sel - TW'(1));
      taps_eff = (taps_sel > depth_sel) ? CNTW'(depth_sel) : CNTW'(taps_sel);
      new_ptr  = (ptr_sel == last_off) ? '0 : ptr_sel + OW'(1);
   end

   assign issue    = (state_ff == S_RUN) && (cnt_ff < taps_eff);
   assign run_end  = (state_ff == S_RUN) && (cnt_ff == taps_eff) && !rd_v_ff && !prod_v_ff;
   assign res      = acc_ff[COEF_W-1 +: DATA_W];

   always_comb begin
      sum_part = res;
      for (int b = 1; b < NBANK; b++) begin
         sum_part = sum_part + part_ff[b];
      end
   end

   always_comb begin
      cw_ok   = 1'b0;
      cw_addr = '0;
      if (req_chan.coef_bank == KERNEL_BANK) begin
         cw_ok   = (int'(req_chan.coef_index) < KERNEL_TAPS);
         cw_addr = CAW'(4 * PHASE_TAPS + int'(req_chan.coef_index));
      end else if (req_chan.coef_bank < KERNEL_BANK) begin
         cw_ok   = (int'(req_chan.coef_index) < PHASE_TAPS);
         cw_addr = CAW'(int'(req_chan.coef_bank) * PHASE_TAPS + int'(req_chan.coef_index));
      end
   end

   always_comb begin
      dw_en   = 1'b0;
      dw_addr = base_sel + DAW'(new_ptr);
      dw_data = x_ff;
      if (state_ff == S_CLEAR) begin
         dw_en   = 1'b1;
         dw_addr = clr_ff;
         dw_data = '0;
      end else if (state_ff == S_WRITE) begin
         dw_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (dw_en) begin
         data_mem[dw_addr] <= dw_data;
      end
      rdata_ff <= data_mem[base_sel + DAW'(off_ff)];
   end

   always_ff @(posedge clock) begin
      if (req_xfer && req_chan.func == FUNC_COEF && cw_ok) begin
         coef_mem[cw_addr] <= req_chan.coef_value;
      end
      rcoef_ff <= coef_mem[cbase_sel + CAW'(cnt_ff)];
   end

   always_ff @(posedge clock) begin
      prod_ff <= ACC_W'(rdata_ff * rcoef_ff);
      if (reset) begin
         state_ff     <= S_CLEAR;
         job_ff       <= JOB_DEC;
         phase_ff     <= '0;
         bank_ff      <= '0;
         low_ff       <= '0;
         kptr_ff      <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         rd_v_ff      <= 1'b0;
         prod_v_ff    <= 1'b0;
         acc_ff       <= '0;
         clr_ff       <= '0;
         rsp_v_ff     <= 1'b0;
         taps_kern_ff <= KERN_TAPS_W'(KERNEL_TAPS);
         for (int b = 0; b < NBANK; b++) begin
            part_ff[b]      <= '0;
            dptr_ff[b]      <= '0;
            iptr_ff[b]      <= '0;
            taps_bank_ff[b] <= BANK_TAPS_W'(PHASE_TAPS);
         end
      end else begin
         if (cfg_wr) begin
            if (cfg_idx == REG_TAPS_KERNEL) begin
               taps_kern_ff <= pwdata[KERN_TAPS_W-1:0];
            end else if (cfg_idx < REG_TAPS_KERNEL) begin
               taps_bank_ff[cfg_idx[1:0]] <= pwdata[BANK_TAPS_W-1:0];
            end
         end
         if (rsp_v_ff && rsp_chan.ready && state_ff != S_DONE) begin
            rsp_v_ff <= 1'b0;
         end
         rd_v_ff   <= issue;
         prod_v_ff <= rd_v_ff;
         if (prod_v_ff) begin
            acc_ff <= acc_ff + prod_ff;
         end
         if (issue) begin
            cnt_ff <= cnt_ff + CNTW'(1);
            off_ff <= (off_ff == '0) ? last_off : off_ff - OW'(1);
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + DAW'(1);
               if (clr_ff == DAW'(DM - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_xfer && req_chan.func == FUNC_SAMPLE) begin
                  job_ff   <= JOB_DEC;
                  bank_ff  <= 2'(3'd4 - 3'(phase_ff));
                  x_ff     <= req_chan.sample_in;
                  state_ff <= S_WRITE;
               end
            end
            S_WRITE: begin
               case (job_ff)
                  JOB_DEC: dptr_ff[bank_ff] <= new_ptr;
                  JOB_INT: iptr_ff[bank_ff] <= new_ptr;
                  JOB_KER: kptr_ff          <= new_ptr;
                  default: kptr_ff          <= kptr_ff;
               endcase
               off_ff   <= new_ptr;
               cnt_ff   <= '0;
               acc_ff   <= '0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               if (run_end) begin
                  case (job_ff)
                     JOB_DEC: begin
                        state_ff          <= S_WRITE;
                        part_ff[phase_ff] <= res;
                        if (phase_ff == 2'd0) begin
                           job_ff <= JOB_KER;
                           x_ff   <= sum_part;
                        end else begin
                           job_ff  <= JOB_INT;
                           bank_ff <= phase_ff;
                           x_ff    <= low_ff;
                        end
                     end
                     JOB_KER: begin
                        state_ff <= S_WRITE;
                        low_ff   <= res;
                        job_ff   <= JOB_INT;
                        bank_ff  <= phase_ff;
                        x_ff     <= res;
                     end
                     default: begin
                        x_ff     <= res;
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_DONE: begin
               if (!rsp_v_ff || rsp_chan.ready) begin
                  rsp_v_ff <= 1'b1;
                  out_ff   <= {x_ff[DATA_W-3:0], 2'b00};
                  phase_ff <= phase_ff + 2'd1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) prod_v_ff |-> $past(rd_v_ff))
      else $error("product without a read");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> cnt_ff <= taps_eff)
      else $error("tap counter overran");
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(state_ff) == S_DONE)
      else $error("response outside done state");
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |-> !rd_v_ff && !prod_v_ff)
      else $error("transfer during filter pass");
`endif

endmodule
